@@ sv/qau_pkg.sv @@
// Shared types and constants for the quaternion arithmetic unit.
package qau_pkg;

    localparam int QW    = 16;  // Q1.14 component width
    localparam int NITER = 15;  // result bits produced by the normalizer search
    localparam int SQW   = 31;  // square of one component
    localparam int SUMW  = 33;  // sum of four squares
    localparam int RW    = 67;  // search remainder, signed
    localparam int UW    = 49;  // (2*lo-1)*sum, signed

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_ROT  = 2'd1,
        OP_NORM = 2'd2,
        OP_INV  = 2'd3
    } op_t;

    typedef logic signed [QW-1:0] q16_t;
    typedef q16_t [3:0] qvec_t;

    // item fields that ride along with the normalizer
    typedef struct packed {
        op_t   op;
        qvec_t a;
        qvec_t b;
    } side_t;

    // one lane of the normalizer search
    typedef struct packed {
        logic signed [RW-1:0] rem;
        logic signed [UW-1:0] u;
        logic [NITER-1:0]     lo;
    } lane_t;

endpackage

@@ sv/qau_norm.sv @@
// Normalizer pipeline: squares, sum, then one result bit per stage for each component.
module qau_norm
    import qau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  side_t in_side,
    output logic  out_valid,
    output side_t out_side,
    output qvec_t out_n,
    output logic  out_zero
);

    logic             sq_vld_reg;
    side_t            sq_side_reg;
    logic [SQW-1:0]   sq_reg [4];
    logic signed [31:0] sq_next [4];
    q16_t             av [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            av[i]      = in_side.a[i];
            sq_next[i] = av[i] * av[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg <= in_side;
            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i] <= sq_next[i][SQW-1:0];
            end
        end
    end

    // stage 0 holds the starting point of the search, stages 1..NITER one bit each
    logic            vld_reg  [NITER+1];
    side_t           side_reg [NITER+1];
    logic [SUMW-1:0] s_reg    [NITER+1];
    lane_t           lane_reg [NITER+1][4];

    logic [SUMW-1:0] s_next;
    lane_t           lane0_next [4];

    always_comb
    begin
        s_next = SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]) + SUMW'(sq_reg[3]);
        for (int i = 0; i < 4; i++)
        begin
            // remainder = m^2 * 2^30 - (2*0-1)^2 * s
            lane0_next[i].rem = RW'({sq_reg[i], 30'b0}) - RW'(s_next);
            lane0_next[i].u   = -UW'(s_next);
            lane0_next[i].lo  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= NITER; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= sq_vld_reg;
            for (int j = 1; j <= NITER; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= sq_side_reg;
            s_reg[0]    <= s_next;
            for (int i = 0; i < 4; i++)
            begin
                lane_reg[0][i] <= lane0_next[i];
            end
        end
    end

    for (genvar j = 1; j <= NITER; j++)
    begin : g_step
        localparam int K = NITER - j;

        logic signed [RW-1:0] ush   [4];
        logic signed [RW-1:0] ssh   [4];
        logic signed [RW-1:0] trial [4];
        logic                 ok    [4];
        lane_t                nxt   [4];

        // try lo + 2^K: (2lo-1+2^(K+1))^2 s = T + u*2^(K+2) + s*2^(2K+2)
        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                ush[i]   = RW'(lane_reg[j-1][i].u) <<< (K + 2);
                ssh[i]   = RW'(s_reg[j-1]) << (2 * K + 2);
                trial[i] = lane_reg[j-1][i].rem - ush[i] - ssh[i];
                ok[i]    = !lane_reg[j-1][i].lo[NITER-1] && !trial[i][RW-1];
                nxt[i]   = lane_reg[j-1][i];
                if (ok[i])
                begin
                    nxt[i].rem = trial[i];
                    nxt[i].u   = lane_reg[j-1][i].u + (UW'(s_reg[j-1]) << (K + 1));
                    nxt[i].lo  = lane_reg[j-1][i].lo | (NITER'(1) << K);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j] <= side_reg[j-1];
                s_reg[j]    <= s_reg[j-1];
                for (int i = 0; i < 4; i++)
                begin
                    lane_reg[j][i] <= nxt[i];
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            // a zero-length operand passes every trial, so force its result to zero
            if (s_reg[NITER] == '0)
                out_n[i] = '0;
            else if (side_reg[NITER].a[i][QW-1])
                out_n[i] = -QW'(lane_reg[NITER][i].lo);
            else
                out_n[i] = QW'(lane_reg[NITER][i].lo);
        end
    end

    assign out_valid = vld_reg[NITER];
    assign out_side  = side_reg[NITER];
    assign out_zero  = (s_reg[NITER] == '0);

endmodule

@@ sv/quaternion_arith_unit.sv @@
// Quaternion multiply, vector rotate, normalize and inverse, pipelined top level.
//
//  channel   | dir | payload
//  ----------+-----+----------------------------------------------------------
//  s_        | in  | tuser: op; tdata: a_w a_x a_y a_z b_w b_x b_y b_z
//  m_        | out | tdata: r_w r_x r_y r_z; tuser: zero_magnitude saturated
//
// One beat per cycle while the output is not stalled; registered in order: squares, sum,
// 15 normalizer search stages (one result bit each), first Hamilton product, second
// product, round and saturate into the output register.
// Reset clears the valid bits only. The whole pipeline stalls while a result
// waits at the output and m_tready is low; nothing is lost or repeated.
module quaternion_arith_unit
    import qau_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
    input  logic [1:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // r_w, r_x, r_y, r_z
    output logic [1:0]   m_tuser    // zero_magnitude, saturated
);

    function automatic logic signed [31:0] mul16(q16_t x, q16_t y);
        mul16 = x * y;
    endfunction

    function automatic logic signed [49:0] mul34(logic signed [33:0] x, q16_t y);
        mul34 = x * y;
    endfunction

    logic  en;
    logic  out_vld_reg;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    side_t in_side;

    always_comb
    begin
        in_side.op = op_t'(s_tuser);
        for (int i = 0; i < 4; i++)
        begin
            in_side.a[i] = s_tdata[QW*i +: QW];
            in_side.b[i] = s_tdata[QW*(i+4) +: QW];
        end
    end

    logic  nrm_vld;
    side_t nrm_side;
    qvec_t nrm_n;
    logic  nrm_zero;

    qau_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_side   (in_side),
        .out_valid (nrm_vld),
        .out_side  (nrm_side),
        .out_n     (nrm_n),
        .out_zero  (nrm_zero)
    );

    // first product: a*b for multiply, n*(0,v) for rotate
    q16_t               xq [4];
    q16_t               yq [4];
    logic signed [33:0] t_next [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            xq[i] = (nrm_side.op == OP_MUL) ? q16_t'(nrm_side.a[i]) : q16_t'(nrm_n[i]);
            yq[i] = nrm_side.b[i];
        end
        if (nrm_side.op != OP_MUL)
            yq[0] = '0;
        t_next[0] = 34'(mul16(xq[0], yq[0])) - 34'(mul16(xq[1], yq[1]))
                  - 34'(mul16(xq[2], yq[2])) - 34'(mul16(xq[3], yq[3]));
        t_next[1] = 34'(mul16(xq[0], yq[1])) + 34'(mul16(xq[1], yq[0]))
                  + 34'(mul16(xq[2], yq[3])) - 34'(mul16(xq[3], yq[2]));
        t_next[2] = 34'(mul16(xq[0], yq[2])) + 34'(mul16(xq[2], yq[0]))
                  - 34'(mul16(xq[1], yq[3])) + 34'(mul16(xq[3], yq[1]));
        t_next[3] = 34'(mul16(xq[0], yq[3])) + 34'(mul16(xq[3], yq[0]))
                  + 34'(mul16(xq[1], yq[2])) - 34'(mul16(xq[2], yq[1]));
    end

    logic               m1_vld_reg;
    op_t                m1_op_reg;
    qvec_t              m1_n_reg;
    logic               m1_zero_reg;
    logic signed [33:0] m1_t_reg [4];

    // second product t*conj(n), rotate only; multiply passes t through
    q16_t               cq [4];
    logic signed [51:0] acc_next [4];

    always_comb
    begin
        cq[0] = m1_n_reg[0];
        for (int i = 1; i < 4; i++)
        begin
            cq[i] = -q16_t'(m1_n_reg[i]);
        end
        for (int i = 0; i < 4; i++)
        begin
            acc_next[i] = 52'(m1_t_reg[i]);
        end
        if (m1_op_reg == OP_ROT)
        begin
            acc_next[0] = '0;
            acc_next[1] = 52'(mul34(m1_t_reg[0], cq[1])) + 52'(mul34(m1_t_reg[1], cq[0]))
                        + 52'(mul34(m1_t_reg[2], cq[3])) - 52'(mul34(m1_t_reg[3], cq[2]));
            acc_next[2] = 52'(mul34(m1_t_reg[0], cq[2])) + 52'(mul34(m1_t_reg[2], cq[0]))
                        - 52'(mul34(m1_t_reg[1], cq[3])) + 52'(mul34(m1_t_reg[3], cq[1]));
            acc_next[3] = 52'(mul34(m1_t_reg[0], cq[3])) + 52'(mul34(m1_t_reg[3], cq[0]))
                        + 52'(mul34(m1_t_reg[1], cq[2])) - 52'(mul34(m1_t_reg[2], cq[1]));
        end
    end

    logic               m2_vld_reg;
    op_t                m2_op_reg;
    qvec_t              m2_n_reg;
    logic               m2_zero_reg;
    logic signed [51:0] m2_acc_reg [4];

    // round half up, saturate, pick the result for the op
    logic signed [51:0] rnd [4];
    logic               clip [4];
    q16_t               sat [4];
    qvec_t              r_next;
    logic               zero_next;
    logic               clip_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (m2_op_reg == OP_ROT)
                rnd[i] = (m2_acc_reg[i] + 52'sd134217728) >>> 28;
            else
                rnd[i] = (m2_acc_reg[i] + 52'sd8192) >>> 14;
            clip[i] = 1'b0;
            sat[i]  = rnd[i][QW-1:0];
            if (rnd[i] > 52'sd32767)
            begin
                sat[i]  = 16'sh7fff;
                clip[i] = 1'b1;
            end
            else if (rnd[i] < -52'sd32768)
            begin
                sat[i]  = 16'sh8000;
                clip[i] = 1'b1;
            end
        end
        r_next    = '0;
        zero_next = 1'b0;
        clip_next = 1'b0;
        case (m2_op_reg)
            OP_MUL:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    r_next[i] = sat[i];
                end
                clip_next = clip[0] || clip[1] || clip[2] || clip[3];
            end
            OP_ROT:
            begin
                if (m2_zero_reg)
                    zero_next = 1'b1;
                else
                begin
                    for (int i = 1; i < 4; i++)
                    begin
                        r_next[i] = sat[i];
                    end
                    clip_next = clip[1] || clip[2] || clip[3];
                end
            end
            OP_NORM:
            begin
                zero_next = m2_zero_reg;
                r_next    = m2_n_reg;
            end
            default:
            begin
                zero_next = m2_zero_reg;
                r_next[0] = m2_n_reg[0];
                for (int i = 1; i < 4; i++)
                begin
                    r_next[i] = -q16_t'(m2_n_reg[i]);
                end
            end
        endcase
    end

    qvec_t r_reg;
    logic  zero_reg;
    logic  clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_vld_reg  <= nrm_vld;
            m2_vld_reg  <= m1_vld_reg;
            out_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_op_reg   <= nrm_side.op;
            m1_n_reg    <= nrm_n;
            m1_zero_reg <= nrm_zero;
            for (int i = 0; i < 4; i++)
            begin
                m1_t_reg[i] <= t_next[i];
            end
            m2_op_reg   <= m1_op_reg;
            m2_n_reg    <= m1_n_reg;
            m2_zero_reg <= m1_zero_reg;
            for (int i = 0; i < 4; i++)
            begin
                m2_acc_reg[i] <= acc_next[i];
            end
            r_reg    <= r_next;
            zero_reg <= zero_next;
            clip_reg <= clip_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = r_reg;
    assign m_tuser  = {clip_reg, zero_reg};

endmodule
